// ----- rtl/fldc_pkg.sv -----
// Shared types, constants and helper functions of the frontlight dimming duty controller.
// No dependencies; the datapath, controller and top level reference it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fldc_pkg;

  localparam int unsigned MaxPwmBits = 16;
  localparam int unsigned DutyW      = 16;
  localparam int unsigned PmicW      = 12;

  localparam logic [6:0]  PctMax    = 7'd100;
  localparam logic [31:0] RoundHalf = 32'd50;
  localparam logic [31:0] PmicScale = 32'd4095;

  localparam logic [31:0] PctDiv  = 32'd100;
  localparam logic [31:0] LvlDiv  = 32'(254 * 254);
  localparam logic [31:0] PmicDiv = 32'd10000;

  localparam logic [63:0] RecipBase = 64'h1_0000_0000;
  localparam logic [31:0] PctRecip  = 32'(RecipBase / 64'(PctDiv));
  localparam logic [31:0] LvlRecip  = 32'(RecipBase / 64'(LvlDiv));
  localparam logic [31:0] PmicRecip = 32'(RecipBase / 64'(PmicDiv));

  typedef enum logic [1:0] {
    CMD_SET_PERCENT = 2'd0,
    CMD_SET_LEVEL   = 2'd1,
    CMD_TURN_ON     = 2'd2,
    CMD_SET_WARM    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PWM_BITS     = 2'd0,
    REG_ACTIVE_HIGH  = 2'd1,
    REG_DUAL_CHANNEL = 2'd2,
    REG_PMIC_MODE    = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_UPDATE,
    DP_ZERO_TOTAL,
    DP_MUL_PF,
    DP_MUL_NN,
    DP_MUL_NF,
    DP_MUL_PP,
    DP_MUL_PK,
    DP_MUL_TS,
    DP_DIV_REC,
    DP_DIV_BACK,
    DP_FIX_TOTAL,
    DP_FIX_WARM,
    DP_FIX_PMIC,
    DP_FINISH
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_PCT,
    DIV_LVL,
    DIV_PMIC
  } div_e;

  typedef struct packed {
    dp_op_e op;
    div_e   div_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pmic;
    logic dual;
    logic level_mode;
    logic level_zero;
    logic out_full;
  } dp_status_t;

  function automatic logic [31:0] div_const(div_e sel);
    case (sel)
      DIV_LVL:  return LvlDiv;
      DIV_PMIC: return PmicDiv;
      default:  return PctDiv;
    endcase
  endfunction

  function automatic logic [31:0] div_recip(div_e sel);
    case (sel)
      DIV_LVL:  return LvlRecip;
      DIV_PMIC: return PmicRecip;
      default:  return PctRecip;
    endcase
  endfunction

  function automatic logic [DutyW-1:0] pwm_full(logic [4:0] bits);
    logic [4:0] b;
    b = bits;
    if (b == 5'd0) begin
      b = 5'd1;
    end
    if (b > 5'(MaxPwmBits)) begin
      b = 5'(MaxPwmBits);
    end
    return DutyW'(({(DutyW + 1){1'b0}} | (DutyW + 1)'(1)) << b) - DutyW'(1);
  endfunction

  function automatic logic [6:0] sat100(logic [7:0] v);
    return (v > 8'(PctMax)) ? PctMax : v[6:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fldc_in_if.sv -----
// Command channel interface: valid/ready handshake with command and value payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface fldc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

`default_nettype wire

// ----- rtl/fldc_out_if.sv -----
// Duty result channel interface: valid/ready handshake with duty fields and lit flag.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface fldc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cool_duty;
  logic [15:0] warm_duty;
  logic [12:0] pmic_duty_word;
  logic        lit;

  modport source (output valid, cool_duty, warm_duty, pmic_duty_word, lit, input ready);
  modport sink   (input valid, cool_duty, warm_duty, pmic_duty_word, lit, output ready);
endinterface

`default_nettype wire

// ----- rtl/fldc_datapath.sv -----
// Datapath: configuration and dimmer state, shared multiplier, reciprocal divide, output beat.
// Depends on fldc_pkg; driven by fldc_controller through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fldc_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fldc_pkg::ctrl_cmd_t                cmd_i,
  output fldc_pkg::dp_status_t               status_o,
  input  logic                               in_accept_i,
  input  logic [1:0]                         in_command_i,
  input  logic [7:0]                         in_value_i,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [4:0]                         cfg_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [fldc_pkg::DutyW-1:0]         cool_duty_o,
  output logic [fldc_pkg::DutyW-1:0]         warm_duty_o,
  output logic [fldc_pkg::PmicW:0]           pmic_duty_word_o,
  output logic                               lit_o
);

  logic [4:0] pwm_bits_q;
  logic       active_high_q;
  logic       dual_q;
  logic       pmic_q;

  logic [6:0] percent_q;
  logic [7:0] level_q;
  logic       level_mode_q;
  logic [6:0] share_q;
  logic [6:0] last_lit_q;

  logic [1:0] cmd_q;
  logic [7:0] val_q;

  logic [31:0]                     acc_q;
  logic [15:0]                     quo_q;
  logic [31:0]                     prod_q;
  logic [fldc_pkg::DutyW-1:0]      total_q;
  logic [fldc_pkg::DutyW-1:0]      warm_q;
  logic [fldc_pkg::PmicW-1:0]      pmic_duty_q;

  logic                            out_valid_q;
  logic [fldc_pkg::DutyW-1:0]      cool_out_q;
  logic [fldc_pkg::DutyW-1:0]      warm_out_q;
  logic [fldc_pkg::PmicW:0]        word_out_q;
  logic                            lit_out_q;

  logic [fldc_pkg::DutyW-1:0] full;
  logic [6:0]                 sat_val;
  logic [6:0]                 apply_pct;
  logic [14:0]                lvl_x;
  logic [6:0]                 lvl_pct;
  logic [7:0]                 lvl_n;
  logic [31:0]                mul_a;
  logic [31:0]                mul_b;
  logic [63:0]                mul_p;
  logic [31:0]                dsor;
  logic [31:0]                rem;
  logic [15:0]                q_fix;
  logic [fldc_pkg::DutyW-1:0] warm_l;
  logic [fldc_pkg::DutyW-1:0] cool_l;
  logic [fldc_pkg::DutyW-1:0] cool_d;
  logic [fldc_pkg::DutyW-1:0] warm_d;
  logic [fldc_pkg::PmicW:0]   word_d;
  logic                       lit_d;

  assign full      = fldc_pkg::pwm_full(pwm_bits_q);
  assign sat_val   = fldc_pkg::sat100(val_q);
  assign apply_pct = (fldc_pkg::cmd_e'(cmd_q) == fldc_pkg::CMD_TURN_ON) ? last_lit_q : sat_val;
  // level * 100 / 255, exact below 2^16
  assign lvl_x     = 15'(val_q) * 15'(fldc_pkg::PctMax);
  assign lvl_pct   = 7'((16'(lvl_x) + 16'(lvl_x >> 8) + 16'd1) >> 8);
  assign lvl_n     = level_q - 8'd1;
  assign dsor      = fldc_pkg::div_const(cmd_i.div_sel);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      fldc_pkg::DP_MUL_PF: begin
        mul_a = 32'(percent_q);
        mul_b = 32'(full);
      end
      fldc_pkg::DP_MUL_NN: begin
        mul_a = 32'(lvl_n);
        mul_b = 32'(lvl_n);
      end
      fldc_pkg::DP_MUL_NF: begin
        mul_a = acc_q;
        mul_b = 32'(full - fldc_pkg::DutyW'(1));
      end
      fldc_pkg::DP_MUL_PP: begin
        mul_a = 32'(percent_q);
        mul_b = 32'(percent_q);
      end
      fldc_pkg::DP_MUL_PK: begin
        mul_a = acc_q;
        mul_b = fldc_pkg::PmicScale;
      end
      fldc_pkg::DP_MUL_TS: begin
        mul_a = 32'(total_q);
        mul_b = 32'(share_q);
      end
      fldc_pkg::DP_DIV_REC: begin
        mul_a = acc_q;
        mul_b = fldc_pkg::div_recip(cmd_i.div_sel);
      end
      fldc_pkg::DP_DIV_BACK: begin
        mul_a = 32'(quo_q);
        mul_b = dsor;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign rem   = acc_q - prod_q;
  assign q_fix = quo_q + 16'(rem >= dsor);

  always_comb begin
    warm_l = dual_q ? warm_q : '0;
    cool_l = total_q - warm_l;
    cool_d = active_high_q ? cool_l : full - cool_l;
    warm_d = active_high_q ? warm_l : full - warm_l;
    word_d = '0;
    lit_d  = |total_q;
    if (pmic_q) begin
      cool_d = '0;
      warm_d = '0;
      word_d = {|pmic_duty_q, pmic_duty_q};
      lit_d  = |pmic_duty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_bits_q    <= 5'd10;
      active_high_q <= 1'b1;
      dual_q        <= 1'b0;
      pmic_q        <= 1'b0;
    end else if (cfg_we_i) begin
      case (fldc_pkg::reg_e'(cfg_idx_i))
        fldc_pkg::REG_PWM_BITS:     pwm_bits_q    <= cfg_data_i;
        fldc_pkg::REG_ACTIVE_HIGH:  active_high_q <= cfg_data_i[0];
        fldc_pkg::REG_DUAL_CHANNEL: dual_q        <= cfg_data_i[0];
        fldc_pkg::REG_PMIC_MODE:    pmic_q        <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      percent_q    <= '0;
      level_q      <= '0;
      level_mode_q <= 1'b0;
      share_q      <= '0;
      last_lit_q   <= fldc_pkg::PctMax;
    end else if (cmd_i.op == fldc_pkg::DP_UPDATE) begin
      case (fldc_pkg::cmd_e'(cmd_q))
        fldc_pkg::CMD_SET_PERCENT, fldc_pkg::CMD_TURN_ON: begin
          percent_q    <= apply_pct;
          level_mode_q <= 1'b0;
          if (apply_pct != 7'd0) begin
            last_lit_q <= apply_pct;
          end
        end
        fldc_pkg::CMD_SET_LEVEL: begin
          level_q      <= val_q;
          percent_q    <= lvl_pct;
          level_mode_q <= 1'b1;
        end
        fldc_pkg::CMD_SET_WARM: begin
          share_q <= sat_val;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      cmd_q <= in_command_i;
      val_q <= in_value_i;
    end
    case (cmd_i.op)
      fldc_pkg::DP_MUL_PF, fldc_pkg::DP_MUL_TS: acc_q <= mul_p[31:0] + fldc_pkg::RoundHalf;
      fldc_pkg::DP_MUL_NN, fldc_pkg::DP_MUL_NF,
      fldc_pkg::DP_MUL_PP, fldc_pkg::DP_MUL_PK: acc_q <= mul_p[31:0];
      fldc_pkg::DP_DIV_REC:    quo_q       <= 16'(mul_p[63:32]);
      fldc_pkg::DP_DIV_BACK:   prod_q      <= mul_p[31:0];
      fldc_pkg::DP_ZERO_TOTAL: total_q     <= '0;
      fldc_pkg::DP_FIX_TOTAL:  total_q     <= level_mode_q ? q_fix + 16'd1 : q_fix;
      fldc_pkg::DP_FIX_WARM:   warm_q      <= q_fix;
      fldc_pkg::DP_FIX_PMIC:   pmic_duty_q <= q_fix[fldc_pkg::PmicW-1:0];
      fldc_pkg::DP_FINISH: begin
        cool_out_q <= cool_d;
        warm_out_q <= warm_d;
        word_out_q <= word_d;
        lit_out_q  <= lit_d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == fldc_pkg::DP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.pmic       = pmic_q;
  assign status_o.dual       = dual_q;
  assign status_o.level_mode = level_mode_q;
  assign status_o.level_zero = (level_q == 8'd0);
  assign status_o.out_full   = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign cool_duty_o      = cool_out_q;
  assign warm_duty_o      = warm_out_q;
  assign pmic_duty_word_o = word_out_q;
  assign lit_o            = lit_out_q;

endmodule

`default_nettype wire

// ----- rtl/fldc_controller.sv -----
// Sequencer: steps the datapath through state update, multiply and divide, split and output.
// Depends on fldc_pkg; talks to fldc_datapath through ctrl_cmd_t and dp_status_t.
`timescale 1ns / 1ps
`default_nettype none

module fldc_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_accept_i,
  input  fldc_pkg::dp_status_t status_i,
  output fldc_pkg::ctrl_cmd_t  cmd_o,
  output logic                 in_ready_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_MUL_A,
    S_MUL_B,
    S_DREC,
    S_DBACK,
    S_DFIX,
    S_SPLIT,
    S_SREC,
    S_SBACK,
    S_SFIX,
    S_FINISH
  } ctl_state_e;

  ctl_state_e        state_q;
  ctl_state_e        state_d;
  fldc_pkg::div_e    main_sel;

  assign main_sel = status_i.pmic       ? fldc_pkg::DIV_PMIC :
                    status_i.level_mode ? fldc_pkg::DIV_LVL  : fldc_pkg::DIV_PCT;

  always_comb begin
    cmd_o.op      = fldc_pkg::DP_NOP;
    cmd_o.div_sel = fldc_pkg::DIV_PCT;
    state_d       = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept_i) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.op = fldc_pkg::DP_UPDATE;
        state_d  = S_MUL_A;
      end
      S_MUL_A: begin
        if (status_i.pmic) begin
          cmd_o.op = fldc_pkg::DP_MUL_PP;
          state_d  = S_MUL_B;
        end else if (status_i.level_mode) begin
          if (status_i.level_zero) begin
            cmd_o.op = fldc_pkg::DP_ZERO_TOTAL;
            state_d  = S_SPLIT;
          end else begin
            cmd_o.op = fldc_pkg::DP_MUL_NN;
            state_d  = S_MUL_B;
          end
        end else begin
          cmd_o.op = fldc_pkg::DP_MUL_PF;
          state_d  = S_DREC;
        end
      end
      S_MUL_B: begin
        cmd_o.op = status_i.pmic ? fldc_pkg::DP_MUL_PK : fldc_pkg::DP_MUL_NF;
        state_d  = S_DREC;
      end
      S_DREC: begin
        cmd_o.op      = fldc_pkg::DP_DIV_REC;
        cmd_o.div_sel = main_sel;
        state_d       = S_DBACK;
      end
      S_DBACK: begin
        cmd_o.op      = fldc_pkg::DP_DIV_BACK;
        cmd_o.div_sel = main_sel;
        state_d       = S_DFIX;
      end
      S_DFIX: begin
        cmd_o.op      = status_i.pmic ? fldc_pkg::DP_FIX_PMIC : fldc_pkg::DP_FIX_TOTAL;
        cmd_o.div_sel = main_sel;
        state_d       = status_i.pmic ? S_FINISH : S_SPLIT;
      end
      S_SPLIT: begin
        if (status_i.dual) begin
          cmd_o.op = fldc_pkg::DP_MUL_TS;
          state_d  = S_SREC;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SREC: begin
        cmd_o.op = fldc_pkg::DP_DIV_REC;
        state_d  = S_SBACK;
      end
      S_SBACK: begin
        cmd_o.op = fldc_pkg::DP_DIV_BACK;
        state_d  = S_SFIX;
      end
      S_SFIX: begin
        cmd_o.op = fldc_pkg::DP_FIX_WARM;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!status_i.out_full) begin
          cmd_o.op = fldc_pkg::DP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/frontlight_dimming_duty_controller.sv -----
// Top level of the frontlight dimming duty controller: controller plus datapath.
// Depends on fldc_pkg, fldc_in_if, fldc_out_if, fldc_controller, fldc_datapath.
//
// Usage:
//   in_bus carries one dimmer command per beat (command, value); out_bus returns one
//   beat per command with cool/warm PWM duty, PMIC duty word and lit flag. Write
//   configuration through cfg_we_i/cfg_idx_i/cfg_data_i only while idle; not enforced.
// Datapath: one shared 32x32 multiplier does every product, and each constant divide
//   is a reciprocal multiply, a back multiply and a correction step. A command runs
//   a state update, one multiply for percent commands or two in level and PMIC mode,
//   then a divide; level zero skips both. With two channels outside PMIC mode a warm
//   split multiply and divide follow.
// Sequencing: the sequencer handles one command at a time.
// Reset: rst_ni clears the sequencer and output valid, loads pwm_bits 10, active high,
//   single channel, LED PWM mode, percent 0, warm share 0 and last lit percent 100.
// Stall: a finished result waits in the output register; the next command may be
//   taken meanwhile, and its own result waits until the previous beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module frontlight_dimming_duty_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  fldc_in_if.sink          in_bus,
  fldc_out_if.source       out_bus,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [4:0]       cfg_data_i
);

  fldc_pkg::ctrl_cmd_t  ctrl_cmd;
  fldc_pkg::dp_status_t dp_status;
  logic                 in_ready;
  logic                 in_accept;

  assign in_bus.ready = in_ready;
  assign in_accept    = in_bus.valid && in_ready;

  fldc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd),
    .in_ready_o  (in_ready)
  );

  fldc_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .status_o         (dp_status),
    .in_accept_i      (in_accept),
    .in_command_i     (in_bus.command),
    .in_value_i       (in_bus.value),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_bus.ready),
    .out_valid_o      (out_bus.valid),
    .cool_duty_o      (out_bus.cool_duty),
    .warm_duty_o      (out_bus.warm_duty),
    .pmic_duty_word_o (out_bus.pmic_duty_word),
    .lit_o            (out_bus.lit)
  );

endmodule

`default_nettype wire

// ----- rtl/fldc_checker.sv -----
// Port-level checks of the frontlight dimming duty controller, bound to the top level.
// Depends on frontlight_dimming_duty_controller and its channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module fldc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] cool_duty_i,
  input logic [15:0] warm_duty_i,
  input logic [12:0] pmic_duty_word_i,
  input logic        lit_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(cool_duty_i) && $stable(warm_duty_i) && $stable(pmic_duty_word_i) && $stable(lit_i))
    else $error("result payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while previous one in work");

  a_pmic_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (pmic_duty_word_i != 13'd0) |->
      lit_i && (cool_duty_i == 16'd0) && (warm_duty_i == 16'd0))
    else $error("PMIC word mixed with PWM duties");

  a_dark_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !lit_i |-> (pmic_duty_word_i == 13'd0))
    else $error("PMIC word set while unlit");

endmodule

bind frontlight_dimming_duty_controller fldc_checker u_fldc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_bus.valid),
  .in_ready_i       (in_bus.ready),
  .out_valid_i      (out_bus.valid),
  .out_ready_i      (out_bus.ready),
  .cool_duty_i      (out_bus.cool_duty),
  .warm_duty_i      (out_bus.warm_duty),
  .pmic_duty_word_i (out_bus.pmic_duty_word),
  .lit_i            (out_bus.lit)
);

`default_nettype wire
